/* rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Request kinds, result status codes, the per-cell operation struct and
// the default sizes of the store.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DefQueueDepth    = 16;
	localparam int DefValueWidth    = 32;
	localparam int DefPriorityWidth = 16;

	// request kinds on the input channel
	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2,
		STATUS_RSVD  = 2'd3
	} status_t;

	// operation broadcast to every cell in the cycle a request is taken
	typedef struct packed {
		logic ins;
		logic rem;
		logic clr;
	} cell_op_t;

endpackage

/* rtl/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry. On insert it keeps its entry, takes the new entry or
// takes its left neighbor's entry; on remove it takes its right neighbor's.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; #(
	parameter int VALUE_WIDTH    = DefValueWidth,
	parameter int PRIORITY_WIDTH = DefPriorityWidth
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cell_op_t                         op,
	input  logic        [VALUE_WIDTH-1:0]    new_value,
	input  logic signed [PRIORITY_WIDTH-1:0] new_priority,
	// left neighbor (toward the head)
	input  logic                             left_valid,
	input  logic                             left_behind,
	input  logic        [VALUE_WIDTH-1:0]    left_value,
	input  logic signed [PRIORITY_WIDTH-1:0] left_priority,
	// right neighbor (toward the tail)
	input  logic                             right_valid,
	input  logic        [VALUE_WIDTH-1:0]    right_value,
	input  logic signed [PRIORITY_WIDTH-1:0] right_priority,
	// own state
	output logic                             valid,
	output logic                             behind,
	output logic        [VALUE_WIDTH-1:0]    value,
	output logic signed [PRIORITY_WIDTH-1:0] priority_o
);

	logic                             valid_q;
	logic        [VALUE_WIDTH-1:0]    value_q;
	logic signed [PRIORITY_WIDTH-1:0] priority_q;

	// new entry goes ahead of this one: empty slot or strictly lower priority
	assign behind = !valid_q || (priority_q < new_priority);

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op.clr) begin
			valid_q <= 1'b0;
		end else if (op.ins) begin
			valid_q <= valid_q | left_valid;
		end else if (op.rem) begin
			valid_q <= right_valid;
		end
	end

	// entry data
	always_ff @(posedge clk) begin
		if (op.ins && behind) begin
			if (left_behind) begin
				value_q    <= left_value;
				priority_q <= left_priority;
			end else begin
				value_q    <= new_value;
				priority_q <= new_priority;
			end
		end else if (op.rem && !op.clr) begin
			value_q    <= right_value;
			priority_q <= right_priority;
		end
	end

	assign valid      = valid_q;
	assign value      = value_q;
	assign priority_o = priority_q;

endmodule

/* rtl/spq_out_buf.sv */
// ----------------------------------------------------------------------------
// spq_out_buf: result register with skid stage
// Output register plus one spare entry so a new request can be taken
// while a finished result still waits on the output channel.
// ----------------------------------------------------------------------------
module spq_out_buf #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             can_push,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic             out_valid_q;
	logic [WIDTH-1:0] out_data_q;
	logic             skid_valid_q;
	logic [WIDTH-1:0] skid_data_q;
	logic             pop;
	logic             load_out;
	logic             load_skid;

	assign pop       = out_valid_q && out_ready;
	assign can_push  = !skid_valid_q;
	// output register takes new data when empty or drained this cycle
	assign load_out  = push && (!out_valid_q || pop);
	assign load_skid = push && out_valid_q && !pop;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop && skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (load_skid) begin
				skid_valid_q <= 1'b1;
			end
			if (pop && !skid_valid_q && !push) begin
				out_valid_q <= 1'b0;
			end else if (load_out) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// data
	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			out_data_q <= skid_data_q;
		end else if (load_out) begin
			out_data_q <= push_data;
		end
		if (load_skid) begin
			skid_data_q <= push_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* rtl/sorted_priority_queue.sv */
// A request's result is registered in the output register, or in the skid entry while an older result still waits.
// Throughput: one request per cycle while the skid entry is free; every cell of the
// slot chain compares against the new entry and shifts in the same cycle.
// A two-entry result buffer keeps requests flowing while results wait.
// Reset (arst_n, asynchronous) empties the queue and the result buffer.
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue kept in priority order
// A chain of slot cells, head at cell 0. Insert places the entry behind all
// of greater or equal priority; remove takes the head; clear empties all.
// ----------------------------------------------------------------------------
module sorted_priority_queue import spq_pkg::*; #(
	parameter int QUEUE_DEPTH    = DefQueueDepth,
	parameter int VALUE_WIDTH    = DefValueWidth,
	parameter int PRIORITY_WIDTH = DefPriorityWidth
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic        [1:0]                kind,
	input  logic        [VALUE_WIDTH-1:0]    item_value,
	input  logic signed [PRIORITY_WIDTH-1:0] item_priority,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic        [1:0]                status,
	output logic        [VALUE_WIDTH-1:0]    out_value,
	output logic signed [PRIORITY_WIDTH-1:0] out_priority,
	output logic                             is_empty
);

	localparam int ResWidth = 2 + VALUE_WIDTH + PRIORITY_WIDTH + 1;

	logic                             cell_valid  [QUEUE_DEPTH];
	logic                             cell_behind [QUEUE_DEPTH];
	logic        [VALUE_WIDTH-1:0]    cell_value  [QUEUE_DEPTH];
	logic signed [PRIORITY_WIDTH-1:0] cell_pri    [QUEUE_DEPTH];

	logic                             accept;
	logic                             full;
	kind_t                            req_kind;
	cell_op_t                         op;
	status_t                          res_status;
	logic        [VALUE_WIDTH-1:0]    res_value;
	logic signed [PRIORITY_WIDTH-1:0] res_pri;
	logic                             res_empty;
	logic        [ResWidth-1:0]       res_data;
	logic        [ResWidth-1:0]       buf_data;

	assign accept   = in_valid && in_ready;
	assign req_kind = kind_t'(kind);
	assign full     = cell_valid[QUEUE_DEPTH-1];

	// operation to the cells; refused insert and empty remove change nothing
	always_comb begin
		op = '0;
		if (accept) begin
			unique case (req_kind)
				KIND_INSERT: op.ins = !full;
				KIND_REMOVE: op.rem = cell_valid[0];
				KIND_CLEAR:  op.clr = 1'b1;
				default:     op     = '0;
			endcase
		end
	end

	// slot chain
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                             l_valid;
		logic                             l_behind;
		logic        [VALUE_WIDTH-1:0]    l_value;
		logic signed [PRIORITY_WIDTH-1:0] l_pri;
		logic                             r_valid;
		logic        [VALUE_WIDTH-1:0]    r_value;
		logic signed [PRIORITY_WIDTH-1:0] r_pri;

		// head cell sees a full, never-behind neighbor on its left
		if (i == 0) begin : g_head
			assign l_valid  = 1'b1;
			assign l_behind = 1'b0;
			assign l_value  = '0;
			assign l_pri    = '0;
		end else begin : g_left
			assign l_valid  = cell_valid[i-1];
			assign l_behind = cell_behind[i-1];
			assign l_value  = cell_value[i-1];
			assign l_pri    = cell_pri[i-1];
		end

		// tail cell sees an empty neighbor on its right
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign r_valid = 1'b0;
			assign r_value = '0;
			assign r_pri   = '0;
		end else begin : g_right
			assign r_valid = cell_valid[i+1];
			assign r_value = cell_value[i+1];
			assign r_pri   = cell_pri[i+1];
		end

		spq_cell #(
			.VALUE_WIDTH    (VALUE_WIDTH),
			.PRIORITY_WIDTH (PRIORITY_WIDTH)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.op             (op),
			.new_value      (item_value),
			.new_priority   (item_priority),
			.left_valid     (l_valid),
			.left_behind    (l_behind),
			.left_value     (l_value),
			.left_priority  (l_pri),
			.right_valid    (r_valid),
			.right_value    (r_value),
			.right_priority (r_pri),
			.valid          (cell_valid[i]),
			.behind         (cell_behind[i]),
			.value          (cell_value[i]),
			.priority_o     (cell_pri[i])
		);
	end

	// result for the request being taken
	always_comb begin
		res_status = STATUS_OK;
		res_value  = '0;
		res_pri    = '0;
		res_empty  = !cell_valid[0];
		unique case (req_kind)
			KIND_INSERT: begin
				if (full) begin
					res_status = STATUS_FULL;
				end
				res_empty = 1'b0;
			end
			KIND_REMOVE: begin
				if (cell_valid[0]) begin
					res_value = cell_value[0];
					res_pri   = cell_pri[0];
				end else begin
					res_status = STATUS_EMPTY;
				end
				res_empty = !cell_valid[1];
			end
			KIND_CLEAR: res_empty = 1'b1;
			default:    res_empty = !cell_valid[0];
		endcase
	end

	assign res_data = {res_status, res_value, res_pri, res_empty};

	spq_out_buf #(
		.WIDTH (ResWidth)
	) u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res_data),
		.can_push  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (buf_data)
	);

	assign status       = buf_data[ResWidth-1 -: 2];
	assign out_value    = buf_data[PRIORITY_WIDTH+1 +: VALUE_WIDTH];
	assign out_priority = buf_data[1 +: PRIORITY_WIDTH];
	assign is_empty     = buf_data[0];

endmodule
